[hdl/hchsv_pkg.sv]
// Shared constants and types for the hue-cycling HSV to RGB block.
`timescale 1ns / 1ps
package hchsv_pkg;

  // Default widths of the phase accumulator and the color datapath
  localparam int PHASE_BITS_DEF = 32;
  localparam int COLOR_BITS_DEF = 16;

  // Fixed field widths
  localparam int STEP_BITS    = 24;  // Q8.16 seconds
  localparam int Q16_BITS     = 16;  // Q0.16 registers and channels
  localparam int CFG_IDX_BITS = 2;

  // Register reset values
  localparam logic [Q16_BITS-1:0] START_HUE_RST  = 16'd0;
  localparam logic [Q16_BITS-1:0] CYCLE_RATE_RST = 16'd6554;   // 0.10 turn/s
  localparam logic [Q16_BITS-1:0] SATURATION_RST = 16'd55705;  // 0.85
  localparam logic [Q16_BITS-1:0] BRIGHTNESS_RST = 16'd65535;  // full scale

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_HUE  = 2'd0,
    REG_CYCLE_RATE = 2'd1,
    REG_SATURATION = 2'd2,
    REG_BRIGHTNESS = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_INC,
    ST_HUE,
    ST_MUL_C,
    ST_MUL_X,
    ST_OUT
  } state_e;

endpackage

[hdl/hchsv_serial_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module hchsv_serial_mul #(
  parameter int A_BITS = 24,
  parameter int B_BITS = 17
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [A_BITS-1:0]        a_i,
  input  logic [B_BITS-1:0]        b_i,
  output logic                     done_o,
  output logic [A_BITS+B_BITS-1:0] prod_o
);

  localparam int CNT_BITS = $clog2(B_BITS + 1);

  logic [A_BITS-1:0]        a_q, a_d;
  logic [A_BITS+B_BITS-1:0] acc_q, acc_d;
  logic [CNT_BITS-1:0]      cnt_q, cnt_d;
  logic                     done_q, done_d;
  logic [A_BITS:0]          sum;

  always_comb begin
    // upper half plus multiplicand when the current multiplier bit is set
    sum    = {1'b0, acc_q[A_BITS+B_BITS-1:B_BITS]} +
             (acc_q[0] ? {1'b0, a_q} : {(A_BITS+1){1'b0}});
    a_d    = a_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d   = a_i;
      acc_d = {{A_BITS{1'b0}}, b_i};
      cnt_d = CNT_BITS'(B_BITS);
    end else if (cnt_q != '0) begin
      acc_d  = {sum, acc_q[B_BITS-1:1]};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[hdl/hue_cycling_hsv_to_rgb.sv]
// Top level: hue phase accumulator and six-sector HSV to RGB converter.
`timescale 1ns / 1ps
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------
//  in      | in_valid_i / in_ready_o   | time_step_i (Q8.16 s)
//  out     | out_valid_o / out_ready_i | red_o, green_o, blue_o (Q0.16)
//  cfg     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
//  Three products run in turn through one bit-serial multiplier
//  (step*rate, value*sat, chroma*frac). A new word is taken only once
//  the sequencer has put the result into the output register and is
//  back in idle.
//  Reset clears the hue phase, loads the register defaults and empties
//  the output register. A stalled output holds the finished word; the
//  next word may be accepted and is parked before the output stage.
//
module hue_cycling_hsv_to_rgb #(
  parameter int PHASE_BITS = hchsv_pkg::PHASE_BITS_DEF,
  parameter int COLOR_BITS = hchsv_pkg::COLOR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [hchsv_pkg::STEP_BITS-1:0]   time_step_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [hchsv_pkg::Q16_BITS-1:0]    red_o,
  output logic [hchsv_pkg::Q16_BITS-1:0]    green_o,
  output logic [hchsv_pkg::Q16_BITS-1:0]    blue_o,
  // register writes
  input  logic                              cfg_we_i,
  input  logic [hchsv_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [hchsv_pkg::Q16_BITS-1:0]    cfg_data_i
);

  localparam int Q16    = hchsv_pkg::Q16_BITS;
  localparam int MUL_A  = (COLOR_BITS > hchsv_pkg::STEP_BITS) ? COLOR_BITS
                                                              : hchsv_pkg::STEP_BITS;
  localparam int MUL_B  = (COLOR_BITS > Q16 + 1) ? COLOR_BITS : Q16 + 1;
  localparam int PROD_W = MUL_A + MUL_B;
  localparam logic [Q16:0] ONE_TURN = {1'b1, {Q16{1'b0}}};

  // Configuration registers
  logic [Q16-1:0] start_hue_q, cycle_rate_q, saturation_q, brightness_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_hue_q  <= hchsv_pkg::START_HUE_RST;
      cycle_rate_q <= hchsv_pkg::CYCLE_RATE_RST;
      saturation_q <= hchsv_pkg::SATURATION_RST;
      brightness_q <= hchsv_pkg::BRIGHTNESS_RST;
    end else if (cfg_we_i) begin
      unique case (hchsv_pkg::cfg_reg_e'(cfg_idx_i))
        hchsv_pkg::REG_START_HUE:  start_hue_q  <= cfg_data_i;
        hchsv_pkg::REG_CYCLE_RATE: cycle_rate_q <= cfg_data_i;
        hchsv_pkg::REG_SATURATION: saturation_q <= cfg_data_i;
        hchsv_pkg::REG_BRIGHTNESS: brightness_q <= cfg_data_i;
      endcase
    end
  end

  // Q0.16 -> Q0.COLOR_BITS, truncating when narrowing
  logic [Q16+7:0]        sat_ext, val_ext;
  logic [COLOR_BITS-1:0] s_col, v_col;
  assign sat_ext = {saturation_q, 8'd0};
  assign val_ext = {brightness_q, 8'd0};
  assign s_col   = sat_ext[Q16+7 -: COLOR_BITS];
  assign v_col   = val_ext[Q16+7 -: COLOR_BITS];

  // Shared serial multiplier
  logic              mul_start, mul_done;
  logic [MUL_A-1:0]  mul_a;
  logic [MUL_B-1:0]  mul_b;
  logic [PROD_W-1:0] mul_prod;

  hchsv_serial_mul #(
    .A_BITS (MUL_A),
    .B_BITS (MUL_B)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Sequencer and datapath registers
  hchsv_pkg::state_e     state_q, state_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [2:0]            sector_q, sector_d;
  logic [Q16-1:0]        frac_q, frac_d;
  logic [COLOR_BITS-1:0] c_q, c_d, x_q, x_d;
  logic                  out_valid_q, out_valid_d;
  logic [Q16-1:0]        red_q, red_d, green_q, green_d, blue_q, blue_d;

  // Increment: Q8.32 product aligned to Q0.PHASE_BITS (only low 32 bits survive)
  logic [PHASE_BITS+31:0] inc_ext;
  logic [PHASE_BITS-1:0]  inc;
  assign inc_ext = {mul_prod[31:0], {PHASE_BITS{1'b0}}};
  assign inc     = inc_ext[PHASE_BITS+31 -: PHASE_BITS];

  // Hue and sector split
  logic [PHASE_BITS-1:0] start_ext, hue;
  logic [Q16-1:0]        h;
  logic [Q16+2:0]        h6;
  assign start_ext = PHASE_BITS'(start_hue_q) << (PHASE_BITS - Q16);
  assign hue       = phase_q + start_ext;
  assign h         = hue[PHASE_BITS-1 -: Q16];
  assign h6        = ({3'd0, h} << 2) + ({3'd0, h} << 1);

  // Fraction weight: falling edge in odd sectors
  logic [Q16:0] frac_w;
  assign frac_w = sector_q[0] ? (ONE_TURN - {1'b0, frac_q}) : {1'b0, frac_q};

  // Channel levels
  logic [COLOR_BITS-1:0] m_col, xm_col, r_col, g_col, b_col;
  logic [COLOR_BITS+Q16-1:0] r_ext, g_ext, b_ext;
  assign m_col  = v_col - c_q;
  assign xm_col = x_q + m_col;

  always_comb begin
    unique case (sector_q)
      3'd0:    begin r_col = v_col;  g_col = xm_col; b_col = m_col;  end
      3'd1:    begin r_col = xm_col; g_col = v_col;  b_col = m_col;  end
      3'd2:    begin r_col = m_col;  g_col = v_col;  b_col = xm_col; end
      3'd3:    begin r_col = m_col;  g_col = xm_col; b_col = v_col;  end
      3'd4:    begin r_col = xm_col; g_col = m_col;  b_col = v_col;  end
      default: begin r_col = v_col;  g_col = m_col;  b_col = xm_col; end
    endcase
  end

  // Q0.COLOR_BITS -> Q0.16
  assign r_ext = {r_col, {Q16{1'b0}}};
  assign g_ext = {g_col, {Q16{1'b0}}};
  assign b_ext = {b_col, {Q16{1'b0}}};

  logic out_load;
  assign out_load = (state_q == hchsv_pkg::ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    sector_d    = sector_q;
    frac_d      = frac_q;
    c_d         = c_q;
    x_d         = x_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    out_valid_d = out_valid_q;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      hchsv_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mul_start = 1'b1;
          mul_a     = MUL_A'(time_step_i);
          mul_b     = MUL_B'(cycle_rate_q);
          state_d   = hchsv_pkg::ST_MUL_INC;
        end
      end
      hchsv_pkg::ST_MUL_INC: begin
        if (mul_done) begin
          phase_d = phase_q + inc;
          state_d = hchsv_pkg::ST_HUE;
        end
      end
      hchsv_pkg::ST_HUE: begin
        sector_d  = h6[Q16+2:Q16];
        frac_d    = h6[Q16-1:0];
        mul_start = 1'b1;
        mul_a     = MUL_A'(v_col);
        mul_b     = MUL_B'(s_col);
        state_d   = hchsv_pkg::ST_MUL_C;
      end
      hchsv_pkg::ST_MUL_C: begin
        if (mul_done) begin
          c_d       = mul_prod[COLOR_BITS +: COLOR_BITS];
          mul_start = 1'b1;
          mul_a     = MUL_A'(mul_prod[COLOR_BITS +: COLOR_BITS]);
          mul_b     = MUL_B'(frac_w);
          state_d   = hchsv_pkg::ST_MUL_X;
        end
      end
      hchsv_pkg::ST_MUL_X: begin
        if (mul_done) begin
          x_d     = mul_prod[Q16 +: COLOR_BITS];
          state_d = hchsv_pkg::ST_OUT;
        end
      end
      hchsv_pkg::ST_OUT: begin
        if (out_load) begin
          red_d       = r_ext[COLOR_BITS+Q16-1 -: Q16];
          green_d     = g_ext[COLOR_BITS+Q16-1 -: Q16];
          blue_d      = b_ext[COLOR_BITS+Q16-1 -: Q16];
          out_valid_d = 1'b1;
          state_d     = hchsv_pkg::ST_IDLE;
        end
      end
      default: state_d = hchsv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hchsv_pkg::ST_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sector_q <= sector_d;
    frac_q   <= frac_d;
    c_q      <= c_d;
    x_q      <= x_d;
    red_q    <= red_d;
    green_q  <= green_d;
    blue_q   <= blue_d;
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  // Multiplier only finishes while the sequencer waits on it
  a_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == hchsv_pkg::ST_MUL_INC || state_q == hchsv_pkg::ST_MUL_C ||
                  state_q == hchsv_pkg::ST_MUL_X))
    else $error("multiplier done outside a multiply state");

  // Output word only appears from the output state
  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == hchsv_pkg::ST_OUT))
    else $error("result word appeared without output state");

  // Secondary component never exceeds chroma
  a_x_le_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hchsv_pkg::ST_OUT) |-> (x_q <= c_q))
    else $error("secondary component above chroma");

  // A finished word waits while the output register is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hchsv_pkg::ST_OUT && out_valid_q && !out_ready_i)
      |=> (state_q == hchsv_pkg::ST_OUT))
    else $error("finished word left while output stalled");

endmodule

[sim/hue_cycling_hsv_to_rgb_tb.sv]
// Self-checking testbench for the hue-cycling HSV to RGB block.
`timescale 1ns / 1ps

module hue_cycling_hsv_to_rgb_tb;

  // No-progress limit. The slowest legal gap is one word's processing
  // time plus the long output hold-off below plus the idle wait between
  // phases, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 64;   // exceeds one word's processing time
  localparam int HOLD_OFF_CYCLES = 600;  // long output stall for back-pressure
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [hchsv_pkg::Q16_BITS-1:0] red;
    logic [hchsv_pkg::Q16_BITS-1:0] green;
    logic [hchsv_pkg::Q16_BITS-1:0] blue;
  } rgb_t;

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_ready_o;
  logic [hchsv_pkg::STEP_BITS-1:0]    time_step_i = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic [hchsv_pkg::Q16_BITS-1:0]     red_o;
  logic [hchsv_pkg::Q16_BITS-1:0]     green_o;
  logic [hchsv_pkg::Q16_BITS-1:0]     blue_o;
  logic                               cfg_we_i    = 1'b0;
  logic [hchsv_pkg::CFG_IDX_BITS-1:0] cfg_idx_i   = hchsv_pkg::REG_START_HUE;
  logic [hchsv_pkg::Q16_BITS-1:0]     cfg_data_i  = '0;

  hue_cycling_hsv_to_rgb dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .time_step_i (time_step_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Predictor copy of the block state and its registers
  logic [31:0]                    hue_phase_q  = '0;
  logic [hchsv_pkg::Q16_BITS-1:0] start_hue_q  = hchsv_pkg::START_HUE_RST;
  logic [hchsv_pkg::Q16_BITS-1:0] cycle_rate_q = hchsv_pkg::CYCLE_RATE_RST;
  logic [hchsv_pkg::Q16_BITS-1:0] sat_q        = hchsv_pkg::SATURATION_RST;
  logic [hchsv_pkg::Q16_BITS-1:0] bri_q        = hchsv_pkg::BRIGHTNESS_RST;

  rgb_t pending_rgb[$];     // colors still owed by the block, oldest first
  int   mismatch_cnt  = 0;
  int   quiet_cycles  = 0;
  int   send_idle_pct = 0;  // chance per cycle that the sender stays idle
  int   stall_pct     = 0;  // chance per cycle that the receiver stalls
  int   hold_left     = 0;  // cycles of forced output stall still to run

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Advance the hue phase by one tick and convert to RGB. Phase is Q0.32,
  // the increment is the low 32 bits of the Q8.32 product, and the hue fed
  // to the six-sector rule is the top 16 bits of phase + start hue.
  function automatic rgb_t advance_hue_rgb(input logic [hchsv_pkg::STEP_BITS-1:0] step);
    logic [39:0]                    prod;
    logic [31:0]                    hue;
    logic [31:0]                    vs;
    logic [hchsv_pkg::Q16_BITS-1:0] chroma;
    logic [hchsv_pkg::Q16_BITS-1:0] x;
    logic [hchsv_pkg::Q16_BITS-1:0] m;
    logic [18:0]                    h6;
    logic [2:0]                     sector;
    logic [16:0]                    frac;
    logic [32:0]                    cx;
    logic [hchsv_pkg::Q16_BITS-1:0] r;
    logic [hchsv_pkg::Q16_BITS-1:0] g;
    logic [hchsv_pkg::Q16_BITS-1:0] b;
    rgb_t                           res;
    prod        = step * cycle_rate_q;
    hue_phase_q = hue_phase_q + prod[31:0];
    hue         = hue_phase_q + {start_hue_q, 16'h0000};
    vs          = bri_q * sat_q;
    chroma      = vs[31:16];
    h6          = hue[31:16] * 19'd6;
    sector      = h6[18:16];
    // falling edge of the sector ramp in odd sectors
    frac        = sector[0] ? (17'h10000 - {1'b0, h6[15:0]}) : {1'b0, h6[15:0]};
    cx          = chroma * frac;
    x           = cx[31:16];
    m           = bri_q - chroma;   // never negative: chroma <= value
    case (sector)
      3'd0: begin r = chroma; g = x;      b = '0;     end
      3'd1: begin r = x;      g = chroma; b = '0;     end
      3'd2: begin r = '0;     g = chroma; b = x;      end
      3'd3: begin r = '0;     g = x;      b = chroma; end
      3'd4: begin r = x;      g = '0;     b = chroma; end
      default: begin r = chroma; g = '0;  b = x;      end
    endcase
    res.red   = r + m;
    res.green = g + m;
    res.blue  = b + m;
    return res;
  endfunction

  // Register value biased toward the ends of the range
  function automatic logic [hchsv_pkg::Q16_BITS-1:0] pick_q16();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      default: return hchsv_pkg::Q16_BITS'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Time step: mostly full range, some sub-second, some at the ends
  function automatic logic [hchsv_pkg::STEP_BITS-1:0] pick_step();
    case ($urandom_range(5))
      0:       return hchsv_pkg::STEP_BITS'($urandom_range(16'hFFFF));
      1:       return $urandom_range(1) ? '1 : '0;
      default: return hchsv_pkg::STEP_BITS'($urandom_range(24'hFFFFFF));
    endcase
  endfunction

  // Output side: random stalls, or a forced hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result checker: every accepted color is matched against the oldest
  // prediction. Outputs are read just after the edge, i.e. their pre-edge
  // values, so the acceptance seen here is the one the block saw.
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rgb.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected word: rgb %h %h %h", red_o, green_o, blue_o);
      end else begin
        want = pending_rgb.pop_front();
        if (want.red !== red_o || want.green !== green_o || want.blue !== blue_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("rgb mismatch: expected %h %h %h, got %h %h %h",
                     want.red, want.green, want.blue, red_o, green_o, blue_o);
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one tick word; valid stays up with a stable payload until taken.
  // A random idle gap may come first, depending on send_idle_pct.
  task automatic send_tick(input logic [hchsv_pkg::STEP_BITS-1:0] step);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    time_step_i <= step;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rgb.push_back(advance_hue_rgb(step));
  endtask

  // Stop sending, wait for every owed color, then let the pipe go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers back to back; only called while idle
  task automatic program_regs(input logic [hchsv_pkg::Q16_BITS-1:0] hue0, rate, sat, bri);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= hchsv_pkg::REG_START_HUE;
    cfg_data_i <= hue0;
    @(posedge clk_i);
    cfg_idx_i  <= hchsv_pkg::REG_CYCLE_RATE;
    cfg_data_i <= rate;
    @(posedge clk_i);
    cfg_idx_i  <= hchsv_pkg::REG_SATURATION;
    cfg_data_i <= sat;
    @(posedge clk_i);
    cfg_idx_i  <= hchsv_pkg::REG_BRIGHTNESS;
    cfg_data_i <= bri;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    start_hue_q  = hue0;
    cycle_rate_q = rate;
    sat_q        = sat;
    bri_q        = bri;
  endtask

  // Register defaults straight out of reset, zero and full-scale steps
  task automatic test_reset_defaults();
    send_tick('0);
    send_tick('1);
    send_tick(24'h010000);  // one second: a tenth of a turn at default rate
    settle();
  endtask

  // With the rate at zero the phase holds, so the start hue can place the
  // converter hue exactly on each side of every sector boundary (only on it at the half turn)
  task automatic test_sector_edges();
    logic [hchsv_pkg::Q16_BITS-1:0] edges[11];
    edges = '{16'd0, 16'd10922, 16'd10923, 16'd21845, 16'd21846, 16'd32768,
              16'd43690, 16'd43691, 16'd54613, 16'd54614, 16'd65535};
    foreach (edges[i]) begin
      program_regs(edges[i] - hue_phase_q[31:16], '0, '1, '1);
      send_tick(pick_step());
      settle();
    end
  endtask

  // No saturation gives gray, no value gives black, tiny settings stay near black
  task automatic test_gray_and_black();
    program_regs(16'h4000, 16'h1234, '0, 16'h8001);
    send_tick(24'h00C350);
    settle();
    program_regs(16'hA000, 16'h0FFF, '1, '0);
    send_tick(24'h123456);
    settle();
    program_regs('1, '1, 16'h0001, 16'h0001);
    send_tick(24'h7FFFFF);
    settle();
  endtask

  // Fastest rate and largest steps wrap the phase; start hue near a full
  // turn also wraps the summed hue
  task automatic test_phase_wrap();
    program_regs('1, '1, 16'hC000, '1);
    repeat (3) send_tick('1);
    send_tick(24'h800000);
    settle();
  endtask

  // Long output hold-off while words keep coming: the block fills and
  // must stall its input; afterwards everything drains in order
  task automatic test_output_backpressure();
    program_regs(pick_q16(), pick_q16(), pick_q16(), pick_q16());
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = HOLD_OFF_CYCLES;
    repeat (16) send_tick(pick_step());
    settle();
  endtask

  // Random ticks under a given idling mix and a fresh register setting
  task automatic test_random_traffic(input int n, input int idle_pct, input int stall);
    program_regs(pick_q16(), pick_q16(), pick_q16(), pick_q16());
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (n) send_tick(pick_step());
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_sector_edges();
    test_gray_and_black();
    test_phase_wrap();
    test_output_backpressure();

    // Idling mixes: none, sender idle, receiver stalling, both
    repeat (2) begin
      test_random_traffic(215, 0, 0);
      test_random_traffic(215, 79, 0);
      test_random_traffic(215, 0, 79);
      test_random_traffic(215, 31, 31);
    end

    if (mismatch_cnt == 0 && pending_rgb.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
